FILE: sv/rar_pkg.sv
`default_nettype none

package rar_pkg;

    // operation codes on func
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_SUM,
        ST_GCD,
        ST_GCD_WAIT,
        ST_DIVN,
        ST_DIVN_WAIT,
        ST_DIVD,
        ST_DIVD_WAIT,
        ST_DIVQ,
        ST_DIVQ_WAIT,
        ST_FINISH
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // output field widths
    localparam int WHOLE_W = 33;
    localparam int REM_W   = 32;
    localparam int DEN_W   = 31;

endpackage

`default_nettype wire

FILE: sv/rar_div.sv
`default_nettype none

// Restoring shift-subtract divider, one quotient bit per cycle.
module rar_div
    import rar_pkg::*;
#(
    parameter int DW = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output div_stat_t          stat,
    output logic      [DW-1:0] quotient,
    output logic      [DW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW-1:0] quo_next;
    logic [DW-1:0] rem_next;
    logic [DW:0]   rem_shift;
    logic [DW+1:0] diff;

    // one trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        rem_next  = diff[DW+1] ? rem_shift[DW-1:0] : diff[DW-1:0];
        quo_next  = {quo_reg[DW-2:0], ~diff[DW+1]};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/rational_arith_reduce_top.sv
// Sequence: error words go from accept straight to ST_FINISH; mul/div words run
//   two multiply states, ST_SUM, k Euclid remainder divisions and three final
//   divisions, add/sub one more multiply state; all of these divisions share one
//   shift-subtract divider of 2*OPERAND_WIDTH bits (one bit per cycle).
// Throughput: a new word is taken only in ST_IDLE, once the last one has left ST_FINISH for the output register.
// Reset: rst_n asynchronous active low clears sequencer and output valid.
`default_nettype none

module rational_arith_reduce_top
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               func,
    input  wire logic [OPERAND_WIDTH-1:0] a_num,
    input  wire logic [OPERAND_WIDTH-1:0] a_den,
    input  wire logic [OPERAND_WIDTH-1:0] b_num,
    input  wire logic [OPERAND_WIDTH-1:0] b_den,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [WHOLE_W-1:0]            whole,
    output logic [REM_W-1:0]              rem_num,
    output logic [DEN_W-1:0]              res_den,
    output logic                          error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * OPERAND_WIDTH;
    localparam int XW = (DW > WHOLE_W) ? DW : WHOLE_W;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    // operand and working registers
    func_t         func_reg;
    logic          err_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic          an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [DW-1:0] prod_a_reg, prod_b_reg, prod_c_reg;
    logic [DW-1:0] num_reg, den_reg;
    logic          res_neg_reg;
    logic [DW-1:0] x_reg, y_reg;

    logic [WHOLE_W-1:0] whole_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_out_reg;
    logic               error_reg;

    logic          accept;
    logic          in_err;
    logic          load_out;

    logic [W-1:0]  mul_x, mul_y;
    logic [DW-1:0] product;

    logic          div_start;
    logic [DW-1:0] div_dividend, div_divisor;
    div_stat_t     div_stat;
    logic [DW-1:0] div_quo, div_rem;

    logic          sign_a, sign_b, sign_c, t_neg;
    logic [DW-1:0] sum_ab, diff_ab, diff_ba;
    logic [DW-1:0] num_sum;
    logic          num_sum_neg;

    logic [XW-1:0] quo_x, rem_x, den_x, quo_s, rem_s;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_err   = (a_den == '0) || (b_den == '0) ||
                      ((func_t'(func) == FUNC_DIV) && (b_num == '0));

    // shared divider
    rar_div #(
        .DW(DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MUL_A:
            begin
                mul_x = an_reg;
                mul_y = (func_reg == FUNC_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL_B:
            begin
                mul_x = ad_reg;
                mul_y = (func_reg == FUNC_MUL) ? bd_reg : bn_reg;
            end
            default:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign product = mul_x * mul_y;

    // signed combine of the cross products
    always_comb
    begin
        sign_a  = an_neg_reg ^ ((func_reg == FUNC_MUL) ? bn_neg_reg : bd_neg_reg);
        sign_b  = ad_neg_reg ^ ((func_reg == FUNC_MUL) ? bd_neg_reg : bn_neg_reg);
        sign_c  = ad_neg_reg ^ bd_neg_reg;
        t_neg   = sign_b ^ (func_reg == FUNC_SUB);
        sum_ab  = prod_a_reg + prod_b_reg;
        diff_ab = prod_a_reg - prod_b_reg;
        diff_ba = prod_b_reg - prod_a_reg;
        if (sign_a == t_neg)
        begin
            num_sum     = sum_ab;
            num_sum_neg = sign_a;
        end
        else if (prod_a_reg >= prod_b_reg)
        begin
            num_sum     = diff_ab;
            num_sum_neg = sign_a;
        end
        else
        begin
            num_sum     = diff_ba;
            num_sum_neg = t_neg;
        end
    end

    // final sign application; a zero magnitude stays zero
    always_comb
    begin
        quo_x = XW'(div_quo);
        rem_x = XW'(div_rem);
        den_x = XW'(den_reg);
        quo_s = res_neg_reg ? (~quo_x + 1'b1) : quo_x;
        rem_s = res_neg_reg ? (~rem_x + 1'b1) : rem_x;
    end

    // sequencer next state and divider requests
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = x_reg;
        div_divisor  = y_reg;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_err ? ST_FINISH : ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B:
            begin
                if ((func_reg == FUNC_ADD) || (func_reg == FUNC_SUB))
                begin
                    state_next = ST_MUL_C;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_MUL_C: state_next = ST_SUM;
            ST_SUM:   state_next = ST_GCD;
            ST_GCD:
            begin
                if (y_reg == '0)
                begin
                    state_next = ST_DIVN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_GCD;
                end
            end
            ST_DIVN:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = x_reg;
                state_next   = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                div_divisor  = x_reg;
                state_next   = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DIVQ;
                end
            end
            ST_DIVQ:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = den_reg;
                state_next   = ST_DIVQ_WAIT;
            end
            ST_DIVQ_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func_t'(func);
            err_reg    <= in_err;
            an_neg_reg <= a_num[W-1];
            ad_neg_reg <= a_den[W-1];
            bn_neg_reg <= b_num[W-1];
            bd_neg_reg <= b_den[W-1];
            an_reg     <= a_num[W-1] ? (~a_num + 1'b1) : a_num;
            ad_reg     <= a_den[W-1] ? (~a_den + 1'b1) : a_den;
            bn_reg     <= b_num[W-1] ? (~b_num + 1'b1) : b_num;
            bd_reg     <= b_den[W-1] ? (~b_den + 1'b1) : b_den;
        end
        case (state_reg)
            ST_MUL_A: prod_a_reg <= product;
            ST_MUL_B: prod_b_reg <= product;
            ST_MUL_C: prod_c_reg <= product;
            ST_SUM:
            begin
                if ((func_reg == FUNC_ADD) || (func_reg == FUNC_SUB))
                begin
                    num_reg     <= num_sum;
                    den_reg     <= prod_c_reg;
                    res_neg_reg <= num_sum_neg ^ sign_c;
                    x_reg       <= num_sum;
                    y_reg       <= prod_c_reg;
                end
                else
                begin
                    num_reg     <= prod_a_reg;
                    den_reg     <= prod_b_reg;
                    res_neg_reg <= sign_a ^ sign_b;
                    x_reg       <= prod_a_reg;
                    y_reg       <= prod_b_reg;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= div_rem;
                end
            end
            ST_DIVN_WAIT:
            begin
                if (div_stat.done)
                begin
                    num_reg <= div_quo;
                end
            end
            ST_DIVD_WAIT:
            begin
                if (div_stat.done)
                begin
                    den_reg <= div_quo;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            if (err_reg)
            begin
                whole_reg   <= '0;
                rem_reg     <= '0;
                den_out_reg <= DEN_W'(1);
                error_reg   <= 1'b1;
            end
            else
            begin
                whole_reg   <= quo_s[WHOLE_W-1:0];
                rem_reg     <= rem_s[REM_W-1:0];
                den_out_reg <= den_x[DEN_W-1:0];
                error_reg   <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign whole     = whole_reg;
    assign rem_num   = rem_reg;
    assign res_den   = den_out_reg;
    assign error     = error_reg;

`ifndef ASSERT_OFF
    // divider is never restarted while a division runs
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // an accepted word keeps the input side closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input ready right after accept");

    // error words carry the fixed zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (whole == '0 && rem_num == '0 && res_den == DEN_W'(1)))
        else $error("error word with nonzero result");

    // a finished result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("output overwritten before taken");
`endif

endmodule

`default_nettype wire

FILE: sim/rational_arith_reduce_top_test.sv
`timescale 1ns / 100ps

module rational_arith_reduce_top_test
    import rar_pkg::*;
();

    localparam int OPERAND_WIDTH  = 16;
    localparam int RANDOM_WORDS   = 1126;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int TAIL_CYCLES    = 2000;

    // one input word as queued for the driver
    typedef struct packed {
        func_t                    func;
        logic [OPERAND_WIDTH-1:0] a_num;
        logic [OPERAND_WIDTH-1:0] a_den;
        logic [OPERAND_WIDTH-1:0] b_num;
        logic [OPERAND_WIDTH-1:0] b_den;
        logic                     drain_first;   // hold until all results are back
    } frac_word_t;

    // one reduced fraction as the block returns it
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [REM_W-1:0]   rem_num;
        logic [DEN_W-1:0]   res_den;
        logic               error;
    } frac_result_t;

    // sign and magnitude, wide enough for any product
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } sgn_mag_t;

    typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               func = '0;
    logic [OPERAND_WIDTH-1:0] a_num = '0;
    logic [OPERAND_WIDTH-1:0] a_den = '0;
    logic [OPERAND_WIDTH-1:0] b_num = '0;
    logic [OPERAND_WIDTH-1:0] b_den = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [WHOLE_W-1:0]       whole;
    logic [REM_W-1:0]         rem_num;
    logic [DEN_W-1:0]         res_den;
    logic                     error;

    frac_word_t   pending_words[$];
    frac_result_t expected_fracs[$];
    frac_word_t   cur_word;

    int fails        = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int error_words  = 0;
    int op_count[4]  = '{0, 0, 0, 0};
    int idle_cycles  = 0;

    // sender burst shaping
    int burst_left = 4;
    int gap_left   = 0;

    // receiver stall shaping
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_left      = 0;
    int       holdoff_left = 0;
    bit       holdoff_done = 1'b0;

    rational_arith_reduce_top #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .whole    (whole),
        .rem_num  (rem_num),
        .res_den  (res_den),
        .error    (error)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic sgn_mag_t split_operand(input logic [OPERAND_WIDTH-1:0] raw);
        sgn_mag_t                 v;
        logic [OPERAND_WIDTH-1:0] m;
        v.neg = raw[OPERAND_WIDTH-1];
        m     = v.neg ? (~raw + 1'b1) : raw;
        v.mag = 64'(m);
        return v;
    endfunction

    function automatic sgn_mag_t sm_times(input sgn_mag_t p, input sgn_mag_t q);
        sgn_mag_t r;
        r.mag = p.mag * q.mag;
        r.neg = (p.neg != q.neg) && (r.mag != 0);
        return r;
    endfunction

    function automatic sgn_mag_t sm_plus(input sgn_mag_t p, input sgn_mag_t q);
        sgn_mag_t r;
        if (p.neg == q.neg)
        begin
            r.neg = p.neg;
            r.mag = p.mag + q.mag;
        end
        else if (p.mag >= q.mag)
        begin
            r.neg = p.neg;
            r.mag = p.mag - q.mag;
        end
        else
        begin
            r.neg = q.neg;
            r.mag = q.mag - p.mag;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    // cross-multiply, reduce by the gcd, split off the whole part
    function automatic frac_result_t reduce_fraction(input frac_word_t w);
        sgn_mag_t     an, ad, bn, bd, num, den, t;
        logic [63:0]  x, y, r, q, rm, wide;
        logic         neg;
        frac_result_t res;
        an = split_operand(w.a_num);
        ad = split_operand(w.a_den);
        bn = split_operand(w.b_num);
        bd = split_operand(w.b_den);
        res.whole   = '0;
        res.rem_num = '0;
        res.res_den = DEN_W'(1);
        res.error   = 1'b1;
        if (ad.mag == 0 || bd.mag == 0 || (w.func == FUNC_DIV && bn.mag == 0))
            return res;

        case (w.func)
            FUNC_ADD:
            begin
                num = sm_plus(sm_times(an, bd), sm_times(ad, bn));
                den = sm_times(ad, bd);
            end
            FUNC_SUB:
            begin
                t     = sm_times(ad, bn);
                t.neg = !t.neg && (t.mag != 0);
                num   = sm_plus(sm_times(an, bd), t);
                den   = sm_times(ad, bd);
            end
            FUNC_MUL:
            begin
                num = sm_times(an, bn);
                den = sm_times(ad, bd);
            end
            default:
            begin
                num = sm_times(an, bd);
                den = sm_times(ad, bn);
            end
        endcase

        // Euclid on the magnitudes; den is nonzero here
        x = num.mag;
        y = den.mag;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        num.mag = num.mag / x;
        den.mag = den.mag / x;
        neg     = (num.neg != den.neg) && (num.mag != 0);

        q    = num.mag / den.mag;
        rm   = num.mag % den.mag;
        wide = neg ? (64'd0 - q) : q;
        res.whole = wide[WHOLE_W-1:0];
        wide = neg ? (64'd0 - rm) : rm;
        res.rem_num = wide[REM_W-1:0];
        res.res_den = den.mag[DEN_W-1:0];
        res.error   = 1'b0;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_word(input func_t f, input int an, input int ad,
                              input int bn, input int bd, input bit drain);
        frac_word_t w;
        w.func        = f;
        w.a_num       = an[OPERAND_WIDTH-1:0];
        w.a_den       = ad[OPERAND_WIDTH-1:0];
        w.b_num       = bn[OPERAND_WIDTH-1:0];
        w.b_den       = bd[OPERAND_WIDTH-1:0];
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // mix of zero, small values that share factors, extremes and full range
    function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
        int                       sel;
        logic [OPERAND_WIDTH-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            v = '0;
        else if (sel < 40)
        begin
            v = OPERAND_WIDTH'($urandom_range(1, 24));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        else if (sel < 48)
        begin
            case ($urandom_range(0, 3))
                0:       v = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
                1:       v = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
                2:       v = '1;
                default: v = OPERAND_WIDTH'(1);
            endcase
        end
        else
            v = OPERAND_WIDTH'($urandom);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_fracs.push_back(reduce_fraction(cur_word));
                words_sent++;
                op_count[cur_word.func]++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_fracs.size() != 0))
                begin
                    cur_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    func     <= cur_word.func;
                    a_num    <= cur_word.a_num;
                    a_den    <= cur_word.a_den;
                    b_num    <= cur_word.b_num;
                    b_den    <= cur_word.b_den;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: changing stall patterns plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else if (!holdoff_done && results_seen >= 150)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(10, 300);
                end
                else
                    rx_left--;
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
                    default:   out_ready <= ($urandom_range(0, 19) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        frac_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got = {whole, rem_num, res_den, error};
            if (got.error)
                error_words++;
            if (expected_fracs.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected word whole=%0d rem=%0d den=%0d err=%0b", $time,
                         $signed(got.whole), $signed(got.rem_num), got.res_den, got.error);
            end
            else
            begin
                want = expected_fracs.pop_front();
                if (got !== want)
                begin
                    fails++;
                    $display("%0t: mismatch exp whole=%0d rem=%0d den=%0d err=%0b",
                             $time, $signed(want.whole), $signed(want.rem_num),
                             want.res_den, want.error);
                    $display("%0t:          got whole=%0d rem=%0d den=%0d err=%0b",
                             $time, $signed(got.whole), $signed(got.rem_num),
                             got.res_den, got.error);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: no handshake on either side for too long
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_fracs.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Word list, reset and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int         i;
        frac_word_t w;

        // directed words
        queue_word(FUNC_ADD, 1, 2, 1, 3, 1'b0);
        queue_word(FUNC_SUB, 1, 2, 1, 2, 1'b0);            // zero value
        queue_word(FUNC_MUL, 0, 5, 3, 7, 1'b0);
        queue_word(FUNC_DIV, 3, 4, -5, 6, 1'b0);
        queue_word(FUNC_ADD, 1, -2, 1, 3, 1'b0);           // negative denominator
        queue_word(FUNC_ADD, 5, 0, 1, 3, 1'b0);            // zero a_den
        queue_word(FUNC_SUB, 1, 1, 1, 0, 1'b0);            // zero b_den
        queue_word(FUNC_DIV, 1, 1, 0, 5, 1'b0);            // divide by zero
        queue_word(FUNC_MUL, 0, 0, 0, 0, 1'b0);
        queue_word(FUNC_DIV, -32768, 1, 1, -32768, 1'b0);  // largest whole part
        queue_word(FUNC_MUL, -32768, 1, -32768, 1, 1'b0);
        queue_word(FUNC_ADD, 32767, 1, 32767, 1, 1'b0);
        queue_word(FUNC_SUB, -32768, 1, 32767, 1, 1'b0);
        queue_word(FUNC_MUL, 32767, -32768, 32767, -32768, 1'b0);
        queue_word(FUNC_DIV, 1, 32767, 32767, 1, 1'b0);    // reduced denominator 32767 squared
        queue_word(FUNC_ADD, 1, -32768, 1, 32767, 1'b0);
        queue_word(FUNC_DIV, -7, 3, 2, 1, 1'b0);
        queue_word(FUNC_MUL, -1, -1, -1, -1, 1'b0);
        queue_word(FUNC_ADD, -32768, -32768, 32767, 32767, 1'b0);
        queue_word(FUNC_SUB, 5, 3, -7, 3, 1'b0);
        queue_word(FUNC_DIV, 0, 3, 5, 7, 1'b0);
        queue_word(FUNC_DIV, 6, 4, -1, -2, 1'b0);
        queue_word(FUNC_ADD, 'haaaa, 'h5555, 'h5555, 'haaaa, 1'b0);
        queue_word(FUNC_MUL, 12, -8, -10, 15, 1'b0);

        // random words; a few wait for the block to drain first
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            w.func        = func_t'($urandom_range(0, 3));
            w.a_num       = pick_operand();
            w.a_den       = pick_operand();
            w.b_num       = pick_operand();
            w.b_den       = pick_operand();
            w.drain_first = (i == 0) || (i >= 600 && i % 150 == 0);
            pending_words.push_back(w);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_fracs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_fracs.size() != 0)
        begin
            fails++;
            $display("%0t: %0d results never arrived", $time, expected_fracs.size());
        end

        $display("Sent %0d words, checked %0d results, %0d of them error words.",
                 words_sent, results_seen, error_words);
        $display("Mix: add %0d, sub %0d, mul %0d, div %0d; long output stall and drains run.",
                 op_count[FUNC_ADD], op_count[FUNC_SUB], op_count[FUNC_MUL],
                 op_count[FUNC_DIV]);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/rar_pkg.sv
sv/rar_div.sv
sv/rational_arith_reduce_top.sv
sim/rational_arith_reduce_top_test.sv
